@@ src/fnc_pkg.sv @@
// ----------------------------------------------------------------------------
// fnc_pkg: shared types and constants for the frequency to note converter
// Widths, fixed-point constants and the stage word that travels down the
// squaring chain.
// ----------------------------------------------------------------------------
package fnc_pkg;

    localparam int FREQ_W         = 24;
    localparam int FREQ_FRAC_BITS = 8;
    localparam int NOTE_FRAC_BITS = 16;
    localparam int LOG_FRAC_BITS  = 32;
    localparam int MANT_FRAC      = 30;
    localparam int MANT_W         = MANT_FRAC + 1;
    localparam int P_W            = 5;
    localparam int NUM_CELLS      = LOG_FRAC_BITS;
    localparam int D_W            = 44;
    localparam int NOTE_W         = 25;
    localparam int ROUND_W        = 9;
    localparam int PITCH_W        = 4;
    localparam int OCT_W          = 5;
    localparam int NOTE_SHIFT     = LOG_FRAC_BITS - NOTE_FRAC_BITS;
    localparam int PIPE_LATENCY   = NUM_CELLS + 5;

    localparam int DIV_12      = 12;
    localparam int RECIP_12    = 171;
    localparam int RECIP_SHIFT = 11;
    localparam int Q_W         = 5;
    localparam int REF_FREQ    = 440;
    localparam int MIDI_A4     = 69;

    typedef struct packed {
        logic                     invalid;
        logic [P_W-1:0]           p;
        logic [MANT_W-1:0]        m;
        logic [LOG_FRAC_BITS-1:0] frac;
    } stage_t;

    function automatic logic [63:0] log2_fixed_const(input logic [FREQ_W-1:0] x);
        logic [63:0] m;
        logic [63:0] frac;
        int          p;
        p    = 0;
        frac = 64'd0;
        for (int i = 0; i < FREQ_W; i++)
        begin
            if (x[i])
            begin
                p = i;
            end
        end
        m = 64'(x) << (MANT_FRAC - p);
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            m    = (m * m) >> MANT_FRAC;
            frac = frac << 1;
            if (m >= (64'd2 << MANT_FRAC))
            begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        return (64'(p) << LOG_FRAC_BITS) + frac;
    endfunction

    localparam logic [63:0] LOG2_REF = log2_fixed_const(FREQ_W'(REF_FREQ));

    localparam longint D12_OFFSET_L =
        12 * (longint'(LOG2_REF) + (longint'(FREQ_FRAC_BITS) <<< LOG_FRAC_BITS))
        - (longint'(1) <<< (NOTE_SHIFT - 1));

    localparam logic signed [D_W-1:0]    D12_OFFSET = D_W'(D12_OFFSET_L);
    localparam logic signed [NOTE_W-1:0] NOTE_BIAS  =
        NOTE_W'(longint'(MIDI_A4) <<< NOTE_FRAC_BITS);
    localparam logic [NOTE_W:0]          NOTE_HALF  =
        (NOTE_W+1)'(longint'(1) <<< (NOTE_FRAC_BITS - 1));

endpackage

@@ src/fnc_front.sv @@
// ----------------------------------------------------------------------------
// fnc_front: leading-one detection and mantissa normalisation
// Finds the integer part of log2 and aligns the leading one to the top of
// the mantissa for the squaring chain.
// ----------------------------------------------------------------------------
module fnc_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [fnc_pkg::FREQ_W-1:0]  freq_hz,
    output logic                        out_valid,
    output fnc_pkg::stage_t             out_stage
);

    logic                         valid_reg;
    fnc_pkg::stage_t              stage_reg;
    fnc_pkg::stage_t              stage_next;
    logic [fnc_pkg::P_W-1:0]      p;
    logic [fnc_pkg::MANT_W-1:0]   ext;

    always_comb
    begin
        p = '0;
        for (int i = 0; i < fnc_pkg::FREQ_W; i++)
        begin
            if (freq_hz[i])
            begin
                p = fnc_pkg::P_W'(i);
            end
        end
        ext                = fnc_pkg::MANT_W'(freq_hz);
        stage_next.invalid = (freq_hz == '0);
        stage_next.p       = p;
        stage_next.m       = ext << (fnc_pkg::P_W'(fnc_pkg::MANT_FRAC) - p);
        stage_next.frac    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

@@ src/fnc_cell.sv @@
// ----------------------------------------------------------------------------
// fnc_cell: one squaring round of the log2 fraction
// Squares the mantissa, takes one fraction bit from its overflow and
// renormalises, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module fnc_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  fnc_pkg::stage_t in_stage,
    output logic            out_valid,
    output fnc_pkg::stage_t out_stage
);

    logic                              valid_reg;
    fnc_pkg::stage_t                   stage_reg;
    fnc_pkg::stage_t                   stage_next;
    logic [2*fnc_pkg::MANT_W-1:0]      prod;
    logic [fnc_pkg::MANT_W:0]          sq;
    logic                              ge;

    always_comb
    begin
        prod               = (2*fnc_pkg::MANT_W)'(in_stage.m) * (2*fnc_pkg::MANT_W)'(in_stage.m);
        sq                 = prod[fnc_pkg::MANT_FRAC +: fnc_pkg::MANT_W+1];
        ge                 = sq[fnc_pkg::MANT_W];
        stage_next.invalid = in_stage.invalid;
        stage_next.p       = in_stage.p;
        stage_next.m       = ge ? sq[fnc_pkg::MANT_W:1] : sq[fnc_pkg::MANT_W-1:0];
        stage_next.frac    = {in_stage.frac[fnc_pkg::LOG_FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    mant_normalised: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !stage_reg.invalid |-> stage_reg.m[fnc_pkg::MANT_W-1])
        else $error("mantissa left the range [1,2)");

endmodule

@@ src/fnc_back.sv @@
// ----------------------------------------------------------------------------
// fnc_back: note scaling, rounding, pitch class and octave
// Turns log2 of the frequency into the note number, rounds it and splits
// it into pitch class and octave over four registered steps.
// ----------------------------------------------------------------------------
module fnc_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  fnc_pkg::stage_t                     in_stage,
    output logic                                done,
    output logic signed [fnc_pkg::NOTE_W-1:0]   note_fixed,
    output logic signed [fnc_pkg::ROUND_W-1:0]  rounded_note,
    output logic [fnc_pkg::PITCH_W-1:0]         pitch_class,
    output logic signed [fnc_pkg::OCT_W-1:0]    octave_number,
    output logic                                invalid_freq
);

    logic [2:0]                           valid_reg;

    logic signed [fnc_pkg::D_W-1:0]       d12_reg;
    logic signed [fnc_pkg::D_W-1:0]       d12_next;
    logic                                 inv_a_reg;

    logic signed [fnc_pkg::NOTE_W-1:0]    note_b_reg;
    logic signed [fnc_pkg::NOTE_W-1:0]    note_b_next;
    logic                                 inv_b_reg;

    logic signed [fnc_pkg::NOTE_W-1:0]    note_c_reg;
    logic [fnc_pkg::ROUND_W-1:0]          rmag_c_reg;
    logic [fnc_pkg::ROUND_W-1:0]          rmag_c_next;
    logic                                 neg_c_reg;
    logic                                 inv_c_reg;

    logic signed [fnc_pkg::NOTE_W-1:0]    note_reg;
    logic signed [fnc_pkg::ROUND_W-1:0]   round_reg;
    logic [fnc_pkg::PITCH_W-1:0]          pitch_reg;
    logic signed [fnc_pkg::OCT_W-1:0]     oct_reg;
    logic                                 inv_reg;
    logic signed [fnc_pkg::ROUND_W-1:0]   round_next;
    logic [fnc_pkg::PITCH_W-1:0]          pitch_next;
    logic signed [fnc_pkg::OCT_W-1:0]     oct_next;

    logic signed [fnc_pkg::D_W-1:0]       lg;
    logic [fnc_pkg::NOTE_W-1:0]           mag;
    logic [fnc_pkg::NOTE_W:0]             mag_sum;
    logic [2*fnc_pkg::ROUND_W-1:0]        q_prod;
    logic [fnc_pkg::Q_W-1:0]              q;
    logic [fnc_pkg::ROUND_W-1:0]          rem;
    logic signed [fnc_pkg::OCT_W-1:0]     q_signed;

    // scale the log difference by twelve and fold in the offset and rounding half
    always_comb
    begin
        lg       = fnc_pkg::D_W'({in_stage.p, in_stage.frac});
        d12_next = (lg <<< 3) + (lg <<< 2) - fnc_pkg::D12_OFFSET;
    end

    always_comb
    begin
        note_b_next = fnc_pkg::NOTE_W'(d12_reg >>> fnc_pkg::NOTE_SHIFT) + fnc_pkg::NOTE_BIAS;
    end

    // round half away from zero on the magnitude
    always_comb
    begin
        mag         = note_b_reg[fnc_pkg::NOTE_W-1] ? fnc_pkg::NOTE_W'(-note_b_reg)
                                                    : fnc_pkg::NOTE_W'(note_b_reg);
        mag_sum     = (fnc_pkg::NOTE_W+1)'(mag) + fnc_pkg::NOTE_HALF;
        rmag_c_next = fnc_pkg::ROUND_W'(mag_sum >> fnc_pkg::NOTE_FRAC_BITS);
    end

    // divide by twelve through the reciprocal, truncating toward zero
    always_comb
    begin
        q_prod     = (2*fnc_pkg::ROUND_W)'(rmag_c_reg)
                   * (2*fnc_pkg::ROUND_W)'(fnc_pkg::RECIP_12);
        q          = fnc_pkg::Q_W'(q_prod >> fnc_pkg::RECIP_SHIFT);
        rem        = rmag_c_reg - fnc_pkg::ROUND_W'(q) * fnc_pkg::ROUND_W'(fnc_pkg::DIV_12);
        q_signed   = neg_c_reg ? -fnc_pkg::OCT_W'(q) : fnc_pkg::OCT_W'(q);
        round_next = neg_c_reg ? -fnc_pkg::ROUND_W'(rmag_c_reg) : fnc_pkg::ROUND_W'(rmag_c_reg);
        if (neg_c_reg && (rem != '0))
        begin
            pitch_next = fnc_pkg::PITCH_W'(fnc_pkg::DIV_12) - fnc_pkg::PITCH_W'(rem);
        end
        else
        begin
            pitch_next = fnc_pkg::PITCH_W'(rem);
        end
        oct_next = q_signed - fnc_pkg::OCT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
            done      <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        d12_reg    <= d12_next;
        inv_a_reg  <= in_stage.invalid;
        note_b_reg <= note_b_next;
        inv_b_reg  <= inv_a_reg;
        note_c_reg <= note_b_reg;
        rmag_c_reg <= rmag_c_next;
        neg_c_reg  <= note_b_reg[fnc_pkg::NOTE_W-1];
        inv_c_reg  <= inv_b_reg;
        inv_reg    <= inv_c_reg;
        if (inv_c_reg)
        begin
            note_reg  <= '0;
            round_reg <= '0;
            pitch_reg <= '0;
            oct_reg   <= '0;
        end
        else
        begin
            note_reg  <= note_c_reg;
            round_reg <= round_next;
            pitch_reg <= pitch_next;
            oct_reg   <= oct_next;
        end
    end

    assign note_fixed    = note_reg;
    assign rounded_note  = round_reg;
    assign pitch_class   = pitch_reg;
    assign octave_number = oct_reg;
    assign invalid_freq  = inv_reg;

    invalid_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        done && invalid_freq |-> note_fixed == '0 && rounded_note == '0
                                 && pitch_class == '0 && octave_number == '0)
        else $error("invalid beat carries nonzero fields");

    pitch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pitch_class < fnc_pkg::PITCH_W'(fnc_pkg::DIV_12))
        else $error("pitch class out of range");

    octave_matches_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && !invalid_freq && rounded_note >= 0 |-> octave_number >= -1)
        else $error("octave below -1 for non-negative note");

endmodule

@@ src/frequency_to_note_converter.sv @@
// ----------------------------------------------------------------------------
// frequency_to_note_converter: frequency to MIDI note number
// Pipelined log2 by leading-one detection and a chain of squaring cells,
// followed by scaling, rounding and pitch class / octave split.
// ----------------------------------------------------------------------------
// Usage:
//   Drive freq_hz (Hz, 8 fraction bits) and pulse start; the beat is taken at
//   any edge with start high, as busy stays low. A new beat may follow in
//   every cycle.
//   Each result appears on note_fixed, rounded_note, pitch_class,
//   octave_number and invalid_freq for one cycle, marked by done.
//   Throughput is one beat per cycle; the pipeline holds the 32 squaring
//   cells, one fraction bit each, plus the normalise stage and four stages
//   of scaling, rounding and division by twelve.
//   A zero frequency gives invalid_freq high and every other field zero.
//   Reset clears all valid flags, so no done follows for beats in flight.
//   The receiver cannot stall: done carries the beat for exactly one cycle.
// ----------------------------------------------------------------------------
module frequency_to_note_converter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fnc_pkg::FREQ_W-1:0]          freq_hz,
    output logic                                done,
    output logic signed [fnc_pkg::NOTE_W-1:0]   note_fixed,
    output logic signed [fnc_pkg::ROUND_W-1:0]  rounded_note,
    output logic [fnc_pkg::PITCH_W-1:0]         pitch_class,
    output logic signed [fnc_pkg::OCT_W-1:0]    octave_number,
    output logic                                invalid_freq
);

    logic            chain_valid [fnc_pkg::NUM_CELLS+1];
    fnc_pkg::stage_t chain_stage [fnc_pkg::NUM_CELLS+1];

    assign busy = 1'b0;

    fnc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .freq_hz   (freq_hz),
        .out_valid (chain_valid[0]),
        .out_stage (chain_stage[0])
    );

    for (genvar g = 0; g < fnc_pkg::NUM_CELLS; g++)
    begin : g_cell
        fnc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_stage  (chain_stage[g]),
            .out_valid (chain_valid[g+1]),
            .out_stage (chain_stage[g+1])
        );
    end

    fnc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chain_valid[fnc_pkg::NUM_CELLS]),
        .in_stage      (chain_stage[fnc_pkg::NUM_CELLS]),
        .done          (done),
        .note_fixed    (note_fixed),
        .rounded_note  (rounded_note),
        .pitch_class   (pitch_class),
        .octave_number (octave_number),
        .invalid_freq  (invalid_freq)
    );

    done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && rst_n, fnc_pkg::PIPE_LATENCY))
        else $error("result beat without a matching start");

endmodule

@@ dv/frequency_to_note_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_to_note_converter_tb: self-checking bench for the note converter
// Drives a table of directed frequencies (zero, octaves of A, the field
// extremes), then random frequencies spread over every leading-one position
// and bunched around semitone boundaries, with random idle gaps on the
// command side. Each done beat is compared field by field with a typed
// table value or a local predictor of the log2 and rounding chain.
// ----------------------------------------------------------------------------
module frequency_to_note_converter_tb;

    localparam int SEMITONES      = 12;
    localparam int NUM_RANDOM     = 1250;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [fnc_pkg::NOTE_W-1:0]  note;
        logic signed [fnc_pkg::ROUND_W-1:0] rounded;
        logic [fnc_pkg::PITCH_W-1:0]        pitch;
        logic signed [fnc_pkg::OCT_W-1:0]   octave;
        logic                               invalid;
    } note_res_t;

    typedef struct packed {
        logic [fnc_pkg::FREQ_W-1:0] freq;
        logic                       typed;
        note_res_t                  want;
    } dir_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [fnc_pkg::FREQ_W-1:0]          freq_hz;
    logic                                done;
    logic signed [fnc_pkg::NOTE_W-1:0]   note_fixed;
    logic signed [fnc_pkg::ROUND_W-1:0]  rounded_note;
    logic [fnc_pkg::PITCH_W-1:0]         pitch_class;
    logic signed [fnc_pkg::OCT_W-1:0]    octave_number;
    logic                                invalid_freq;

    note_res_t pending_notes[$];
    dir_row_t  dir_rows[$];
    note_res_t head;
    int        errors;
    int        idle_cycles;

    frequency_to_note_converter uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .freq_hz       (freq_hz),
        .done          (done),
        .note_fixed    (note_fixed),
        .rounded_note  (rounded_note),
        .pitch_class   (pitch_class),
        .octave_number (octave_number),
        .invalid_freq  (invalid_freq)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint log2_q32(input logic [fnc_pkg::FREQ_W-1:0] x);
        logic [63:0] mant;
        logic [31:0] fbits;
        int          msb;
        msb   = 0;
        fbits = '0;
        for (int i = 0; i < fnc_pkg::FREQ_W; i++)
        begin
            if (x[i])
            begin
                msb = i;
            end
        end
        mant = {40'd0, x} << (fnc_pkg::MANT_FRAC - msb);
        for (int k = 0; k < fnc_pkg::LOG_FRAC_BITS; k++)
        begin
            mant  = (mant * mant) >> fnc_pkg::MANT_FRAC;
            fbits = {fbits[30:0], 1'b0};
            if (mant >= (64'd2 << fnc_pkg::MANT_FRAC))
            begin
                fbits[0] = 1'b1;
                mant     = mant >> 1;
            end
        end
        return (longint'(msb) <<< fnc_pkg::LOG_FRAC_BITS) + longint'({32'd0, fbits});
    endfunction

    function automatic note_res_t predict_note(input logic [fnc_pkg::FREQ_W-1:0] f);
        note_res_t res;
        longint    d;
        longint    nq;
        longint    mag;
        longint    r;
        longint    pc;
        longint    oct;
        res = '0;
        if (f == '0)
        begin
            res.invalid = 1'b1;
            return res;
        end
        d  = log2_q32(f) - log2_q32(fnc_pkg::FREQ_W'(fnc_pkg::REF_FREQ))
           - (longint'(fnc_pkg::FREQ_FRAC_BITS) <<< fnc_pkg::LOG_FRAC_BITS);
        nq = (longint'(fnc_pkg::MIDI_A4) <<< fnc_pkg::NOTE_FRAC_BITS)
           + ((12 * d + (longint'(1) <<< (fnc_pkg::NOTE_SHIFT - 1)))
              >>> fnc_pkg::NOTE_SHIFT);
        mag = (nq < 0) ? -nq : nq;
        r   = (mag + (longint'(1) <<< (fnc_pkg::NOTE_FRAC_BITS - 1)))
            >>> fnc_pkg::NOTE_FRAC_BITS;
        if (nq < 0)
        begin
            r = -r;
        end
        pc = r % SEMITONES;
        if (pc < 0)
        begin
            pc = pc + SEMITONES;
        end
        oct = r / SEMITONES - 1;
        res.note    = fnc_pkg::NOTE_W'(nq);
        res.rounded = fnc_pkg::ROUND_W'(r);
        res.pitch   = fnc_pkg::PITCH_W'(pc);
        res.octave  = fnc_pkg::OCT_W'(oct);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic add_row(input logic [fnc_pkg::FREQ_W-1:0] f, input logic typed,
                           input longint nq, input longint r, input longint pc,
                           input longint oct, input logic inv);
        dir_row_t row;
        row.freq         = f;
        row.typed        = typed;
        row.want.note    = fnc_pkg::NOTE_W'(nq);
        row.want.rounded = fnc_pkg::ROUND_W'(r);
        row.want.pitch   = fnc_pkg::PITCH_W'(pc);
        row.want.octave  = fnc_pkg::OCT_W'(oct);
        row.want.invalid = inv;
        dir_rows.push_back(row);
    endtask

    task automatic send_freq(input logic [fnc_pkg::FREQ_W-1:0] f, input note_res_t want);
        start   <= 1'b1;
        freq_hz <= f;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_notes.push_back(want);
    endtask

    // Compare each done beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_notes.size() == 0)
            begin
                report_mismatch("unexpected done beat", 0, 0);
            end
            else
            begin
                head = pending_notes.pop_front();
                if (note_fixed !== head.note)
                    report_mismatch("note_fixed", note_fixed, head.note);
                if (rounded_note !== head.rounded)
                    report_mismatch("rounded_note", rounded_note, head.rounded);
                if (pitch_class !== head.pitch)
                    report_mismatch("pitch_class", pitch_class, head.pitch);
                if (octave_number !== head.octave)
                    report_mismatch("octave_number", octave_number, head.octave);
                if (invalid_freq !== head.invalid)
                    report_mismatch("invalid_freq", invalid_freq, head.invalid);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [fnc_pkg::FREQ_W-1:0] f;
        note_res_t                  want;
        int                         sel;
        int                         msb;
        int                         semi;
        int                         gap;
        bit                         calm;
        real                        fr;
        longint                     fv;

        rst_n       = 1'b0;
        start       = 1'b0;
        freq_hz     = '0;

        // Octaves of A are exact: the mantissa is unchanged, only the shift moves
        add_row(24'd0,        1'b1, 0,        0,   0, 0,  1'b1);
        add_row(24'd112640,   1'b1, 4521984,  69,  9, 4,  1'b0);
        add_row(24'd225280,   1'b1, 5308416,  81,  9, 5,  1'b0);
        add_row(24'd56320,    1'b1, 3735552,  57,  9, 3,  1'b0);
        add_row(24'd7040,     1'b1, 1376256,  21,  9, 0,  1'b0);
        add_row(24'd3520,     1'b1, 589824,   9,   9, -1, 1'b0);
        add_row(24'd1760,     1'b1, -196608,  -3,  9, -1, 1'b0);
        add_row(24'd880,      1'b1, -983040,  -15, 9, -2, 1'b0);
        add_row(24'd440,      1'b1, -1769472, -27, 9, -3, 1'b0);
        add_row(24'd220,      1'b1, -2555904, -39, 9, -4, 1'b0);
        add_row(24'd110,      1'b1, -3342336, -51, 9, -5, 1'b0);
        add_row(24'd1,        1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'hFFFFFF,   1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'h800000,   1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'h7FFFFF,   1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'hAAAAAA,   1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'h555555,   1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'h000100,   1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'd66976,    1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'd3,        1'b0, 0, 0, 0, 0, 1'b0);
        add_row(24'd0,        1'b1, 0,        0,   0, 0,  1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            want = dir_rows[i].typed ? dir_rows[i].want : predict_note(dir_rows[i].freq);
            send_freq(dir_rows[i].freq, want);
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            calm = ((n / 100) % 3) == 0;
            sel  = $urandom_range(0, 99);
            if (sel < 4)
            begin
                f = '0;
            end
            else if (sel < 24)
            begin
                f = fnc_pkg::FREQ_W'($urandom);
            end
            else if (sel < 44)
            begin
                // Land a few codes either side of a half-semitone boundary
                semi = $urandom_range(0, 285);
                fr   = 440.0 * 256.0 * (2.0 ** ((real'(semi - 132) + 0.5 - 69.0) / 12.0));
                fv   = longint'($rtoi(fr)) + longint'($urandom_range(0, 6)) - 3;
                if (fv < 1)
                    fv = 1;
                if (fv > 64'hFFFFFF)
                    fv = 64'hFFFFFF;
                f = fnc_pkg::FREQ_W'(fv);
            end
            else
            begin
                msb = $urandom_range(0, fnc_pkg::FREQ_W - 1);
                f   = fnc_pkg::FREQ_W'($urandom)
                    & fnc_pkg::FREQ_W'((longint'(1) <<< msb) - 1);
                f[msb] = 1'b1;
            end

            if (!calm)
            begin
                sel = $urandom_range(0, 99);
                gap = (sel < 65) ? 0 : (sel < 95) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_freq(f, predict_note(f));
        end

        start <= 1'b0;
        while (pending_notes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (fnc_pkg::PIPE_LATENCY + 8) @(posedge clk);

        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
